// File: rtl/ppb_pkg.sv
// shared types and constants for the projected point bounds unit
`timescale 1ns / 1ps
package ppb_pkg;

    localparam int COORD_BITS_DEF    = 32;
    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 64;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_U_XY,
        CFG_U_ZW,
        CFG_V_XY,
        CFG_V_ZW,
        CFG_W_XY,
        CFG_W_ZW,
        CFG_MATRIX_VALID
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] u_xy;
        logic [63:0] u_zw;
        logic [63:0] v_xy;
        logic [63:0] v_zw;
        logic [63:0] w_xy;
        logic [63:0] w_zw;
        logic        matrix_valid;
    } t_cfg;

    // one classified point handed from front to back
    typedef struct packed {
        logic signed [63:0] num_u;
        logic signed [63:0] num_v;
        logic        [63:0] den;
        logic               proj;
        logic               mv;
        logic               last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_COL_W,
        FR_COL_U,
        FR_COL_V,
        FR_SUM_V,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage

// File: rtl/ppb_front.sv
// front end: accepts points, forms clip x, y, w and classifies them
`timescale 1ns / 1ps
module ppb_front #(
    parameter int COORD_BITS = ppb_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppb_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [COORD_BITS-1:0] i_pos_z,
    input  logic                  i_last,
    output logic                  o_push,
    output ppb_pkg::t_entry       o_entry,
    input  ppb_pkg::t_q_status    i_q
);
    import ppb_pkg::*;

    localparam int PRE = (COORD_BITS > 32) ? COORD_BITS - 32 : 0;
    localparam int TSH = 21 - PRE;

    t_front_state r_state, n_state;

    logic signed [31:0] w_x, w_y, w_z;
    logic signed [31:0] r_x, r_y, r_z;
    logic               r_last;
    logic signed [31:0] w_a, w_b, w_c, w_t;
    logic signed [63:0] w_m0, w_m1, w_m2;
    logic signed [63:0] r_p0, r_p1, r_p2;
    logic signed [31:0] r_t;
    logic signed [63:0] w_sum;
    logic signed [63:0] r_cw, r_cx, r_cy;
    logic               w_proj, w_keep;

    // coordinates narrowed to 32 bits, rounding down, or sign-extended when narrower
    generate
        if (COORD_BITS >= 32) begin : g_narrow
            assign w_x = i_pos_x[COORD_BITS-1 -: 32];
            assign w_y = i_pos_y[COORD_BITS-1 -: 32];
            assign w_z = i_pos_z[COORD_BITS-1 -: 32];
        end else begin : g_widen
            assign w_x = {{(32-COORD_BITS){i_pos_x[COORD_BITS-1]}}, i_pos_x};
            assign w_y = {{(32-COORD_BITS){i_pos_y[COORD_BITS-1]}}, i_pos_y};
            assign w_z = {{(32-COORD_BITS){i_pos_z[COORD_BITS-1]}}, i_pos_z};
        end
    endgenerate

    always_comb begin
        case (r_state)
            FR_COL_W: begin
                w_a = i_cfg.w_xy[31:0];
                w_b = i_cfg.w_xy[63:32];
                w_c = i_cfg.w_zw[31:0];
                w_t = i_cfg.w_zw[63:32];
            end
            FR_COL_U: begin
                w_a = i_cfg.u_xy[31:0];
                w_b = i_cfg.u_xy[63:32];
                w_c = i_cfg.u_zw[31:0];
                w_t = i_cfg.u_zw[63:32];
            end
            default: begin
                w_a = i_cfg.v_xy[31:0];
                w_b = i_cfg.v_xy[63:32];
                w_c = i_cfg.v_zw[31:0];
                w_t = i_cfg.v_zw[63:32];
            end
        endcase
    end

    assign w_m0  = r_x * w_a;
    assign w_m1  = r_y * w_b;
    assign w_m2  = r_z * w_c;
    assign w_sum = (r_p0 >>> 3) + (r_p1 >>> 3) + (r_p2 >>> 3) + (64'(r_t) <<< TSH);

    assign w_proj = i_cfg.matrix_valid && (r_cw > 64'sd0);
    assign w_keep = w_proj || r_last;

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            FR_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = FR_COL_W;
            end
            FR_COL_W: n_state = FR_COL_U;
            FR_COL_U: n_state = FR_COL_V;
            FR_COL_V: n_state = FR_SUM_V;
            FR_SUM_V: n_state = FR_PUSH;
            FR_PUSH: begin
                // points that neither project nor close a set are dropped here
                if (!w_keep) begin
                    n_state = FR_IDLE;
                end else if (!i_q.full) begin
                    o_push  = 1'b1;
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= FR_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FR_IDLE && i_valid) begin
            r_x    <= w_x;
            r_y    <= w_y;
            r_z    <= w_z;
            r_last <= i_last;
        end
        if (r_state == FR_COL_W || r_state == FR_COL_U || r_state == FR_COL_V) begin
            r_p0 <= w_m0;
            r_p1 <= w_m1;
            r_p2 <= w_m2;
            r_t  <= w_t;
        end
        if (r_state == FR_COL_U) r_cw <= w_sum;
        if (r_state == FR_COL_V) r_cx <= w_sum;
        if (r_state == FR_SUM_V) r_cy <= w_sum;
    end

    assign o_entry.num_u = r_cx + r_cw;
    assign o_entry.num_v = r_cw - r_cy;
    assign o_entry.den   = 64'(r_cw) << 1;
    assign o_entry.proj  = w_proj;
    assign o_entry.mv    = i_cfg.matrix_valid;
    assign o_entry.last  = r_last;

endmodule

// File: rtl/ppb_fifo.sv
// two-entry queue between front and back
`timescale 1ns / 1ps
module ppb_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ppb_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output ppb_pkg::t_entry    o_entry,
    output ppb_pkg::t_q_status o_status
);
    import ppb_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_entry         = r_mem[r_rp];
    assign o_status.full   = (r_cnt == 2'd2);
    assign o_status.empty  = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

endmodule

// File: rtl/ppb_div.sv
// restoring divider: floor(num * 2^f / den), saturated to 32 bits
`timescale 1ns / 1ps
module ppb_div #(
    parameter int OUT_FRAC_BITS = ppb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic        [63:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int NW = 64 + OUT_FRAC_BITS;
    localparam int QB = 31;
    localparam int CW = $clog2(QB + 1);

    logic [63:0]    w_mag;
    logic [NW-1:0]  w_n;
    logic [63:0]    w_r0;
    logic           w_sat;
    logic [64:0]    w_sh;
    logic           w_ge;
    logic [64:0]    w_diff;
    logic [31:0]    w_adj;

    logic           r_busy, r_done, r_neg;
    logic [CW-1:0]  r_cnt;
    logic [63:0]    r_den, r_rem;
    logic [QB-1:0]  r_nlow, r_q;
    logic signed [31:0] r_res;

    assign w_mag  = i_num[63] ? (~i_num + 64'd1) : i_num;
    assign w_n    = {w_mag, {OUT_FRAC_BITS{1'b0}}};
    // integer part too large when the top bits alone already reach den
    assign w_r0   = 64'(w_n[NW-1:QB]);
    assign w_sat  = (w_r0 >= i_den);

    assign w_sh   = {r_rem, r_nlow[QB-1]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_adj  = {1'b0, r_q} + {31'd0, (r_rem != 64'd0)};

    // done stays high from the end of a division until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[63];
            r_den  <= i_den;
            r_rem  <= w_r0;
            r_nlow <= w_n[QB-1:0];
            r_q    <= '0;
            r_cnt  <= CW'(QB);
            if (w_sat) r_res <= i_num[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem  <= w_ge ? w_diff[63:0] : w_sh[63:0];
                r_q    <= {r_q[QB-2:0], w_ge};
                r_nlow <= {r_nlow[QB-2:0], 1'b0};
                r_cnt  <= r_cnt - CW'(1);
            end else begin
                r_res <= r_neg ? -$signed(w_adj) : $signed({1'b0, r_q});
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

// File: rtl/ppb_back.sv
// back end: divides, keeps running bounds and holds the result register
`timescale 1ns / 1ps
module ppb_back #(
    parameter int OUT_FRAC_BITS = ppb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ppb_pkg::t_q_status     i_q,
    input  ppb_pkg::t_entry        i_entry,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_FRAC_BITS:0] o_u_min,
    output logic [OUT_FRAC_BITS:0] o_v_min,
    output logic [OUT_FRAC_BITS:0] o_u_max,
    output logic [OUT_FRAC_BITS:0] o_v_max,
    output logic                   o_found
);
    import ppb_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< OUT_FRAC_BITS;

    t_back_state r_state, n_state;
    t_entry      r_ent;
    logic        w_start, w_done_u, w_done_v, w_load, w_found;
    logic signed [31:0] w_u, w_v;
    logic signed [31:0] r_umin, r_vmin, r_umax, r_vmax;
    logic        r_any, r_ov;
    logic [OUT_FRAC_BITS:0] r_oumin, r_ovmin, r_oumax, r_ovmax;
    logic        r_ofound;

    function automatic logic [OUT_FRAC_BITS:0] clamp(input logic signed [31:0] v);
        if (v < 32'sd0)  return '0;
        else if (v > ONE) return ONE[OUT_FRAC_BITS:0];
        else             return v[OUT_FRAC_BITS:0];
    endfunction

    assign w_start = o_pop && i_entry.proj;
    assign w_found = r_ent.mv && r_any;

    ppb_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(i_entry.num_u), .i_den(i_entry.den), .o_done(w_done_u), .o_quot(w_u)
    );

    ppb_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(i_entry.num_v), .i_den(i_entry.den), .o_done(w_done_v), .o_quot(w_v)
    );

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q.empty) begin
                    o_pop = 1'b1;
                    if (i_entry.proj)      n_state = BK_DIV;
                    else if (i_entry.last) n_state = BK_EMIT;
                end
            end
            BK_DIV: begin
                // a saturating divider finishes early and holds its done flag
                if (w_done_u && w_done_v) n_state = r_ent.last ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT: begin
                if (!r_ov || i_ready) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
            r_any   <= 1'b0;
            r_umin  <= 32'sh7fff_ffff;
            r_vmin  <= 32'sh7fff_ffff;
            r_umax  <= 32'sh8000_0000;
            r_vmax  <= 32'sh8000_0000;
        end else begin
            r_state <= n_state;
            if (w_load)            r_ov <= 1'b1;
            else if (i_ready)      r_ov <= 1'b0;
            if (w_load) begin
                r_any  <= 1'b0;
                r_umin <= 32'sh7fff_ffff;
                r_vmin <= 32'sh7fff_ffff;
                r_umax <= 32'sh8000_0000;
                r_vmax <= 32'sh8000_0000;
            end else if (r_state == BK_DIV && w_done_u && w_done_v) begin
                r_any <= 1'b1;
                if (w_u < r_umin) r_umin <= w_u;
                if (w_v < r_vmin) r_vmin <= w_v;
                if (w_u > r_umax) r_umax <= w_u;
                if (w_v > r_vmax) r_vmax <= w_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_ent <= i_entry;
        if (w_load) begin
            r_oumin  <= w_found ? clamp(r_umin) : '0;
            r_ovmin  <= w_found ? clamp(r_vmin) : '0;
            r_oumax  <= w_found ? clamp(r_umax) : '0;
            r_ovmax  <= w_found ? clamp(r_vmax) : '0;
            r_ofound <= w_found;
        end
    end

    assign o_valid = r_ov;
    assign o_u_min = r_oumin;
    assign o_v_min = r_ovmin;
    assign o_u_max = r_oumax;
    assign o_v_max = r_ovmax;
    assign o_found = r_ofound;

endmodule

// File: rtl/projected_point_bounds_unit.sv
// top level of the projected point bounds unit
`timescale 1ns / 1ps
// Projects a stream of Q8.24 points through three matrix columns, skips points
// with non-positive clip w or no valid matrix and tracks the screen-space u,v
// box, emitting it in Q1.16 with a found flag on the point marked last. The
// front forms the three column products with three multipliers, then the sums,
// and the back pops a point and runs the two 31-step dividers side by side; a
// divider whose ratio saturates finishes early. A point that closes a set also
// passes through an emit state that loads the result register. A two-entry
// queue lets the front work on the next point while the back divides. Skipped
// points that do not close a set are dropped in the front, not queued.
module projected_point_bounds_unit #(
    parameter int COORD_BITS    = ppb_pkg::COORD_BITS_DEF,
    parameter int OUT_FRAC_BITS = ppb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ppb_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [ppb_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // pos_x, pos_y, pos_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    input  logic                                   i_s_tlast,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // box_u_min, box_v_min, box_u_max, box_v_max
    output logic [((4*(OUT_FRAC_BITS+1)+7)/8)*8-1:0] o_m_tdata,
    // box_found
    output logic                                   o_m_tuser
);
    import ppb_pkg::*;

    localparam int OUT_W = ((4*(OUT_FRAC_BITS+1)+7)/8)*8;
    localparam int EW    = OUT_FRAC_BITS + 1;

    t_cfg      r_cfg;
    t_entry    w_push_entry, w_pop_entry;
    t_q_status w_q;
    logic      w_push, w_pop;
    logic [OUT_FRAC_BITS:0] w_umin, w_vmin, w_umax, w_vmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_U_XY:         r_cfg.u_xy <= i_cfg_data;
                CFG_U_ZW:         r_cfg.u_zw <= i_cfg_data;
                CFG_V_XY:         r_cfg.v_xy <= i_cfg_data;
                CFG_V_ZW:         r_cfg.v_zw <= i_cfg_data;
                CFG_W_XY:         r_cfg.w_xy <= i_cfg_data;
                CFG_W_ZW:         r_cfg.w_zw <= i_cfg_data;
                CFG_MATRIX_VALID: r_cfg.matrix_valid <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ppb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_pos_x (i_s_tdata[COORD_BITS-1:0]),
        .i_pos_y (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_pos_z (i_s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_last  (i_s_tlast),
        .o_push  (w_push),
        .o_entry (w_push_entry),
        .i_q     (w_q)
    );

    ppb_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_pop_entry),
        .o_status (w_q)
    );

    ppb_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .i_entry (w_pop_entry),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_u_min (w_umin),
        .o_v_min (w_vmin),
        .o_u_max (w_umax),
        .o_v_max (w_vmax),
        .o_found (o_m_tuser)
    );

    assign o_m_tdata = OUT_W'({w_vmax, w_umax, w_vmin, w_umin});

    // the queue is never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q.full)
        else $error("queue written while full");

    // an empty box carries all-zero edges
    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("box not found but edges non-zero");

    // every edge lies within [0, 1]
    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_umin <= EW'(1) << OUT_FRAC_BITS)
                    && (w_vmin <= EW'(1) << OUT_FRAC_BITS)
                    && (w_umax <= EW'(1) << OUT_FRAC_BITS)
                    && (w_vmax <= EW'(1) << OUT_FRAC_BITS))
        else $error("box edge above one");

    // the back never reads from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q.empty)
        else $error("queue read while empty");

endmodule

// File: bench/projected_point_bounds_unit_tb.sv
// self-checking testbench for the projected point bounds unit
`timescale 1ns / 1ps
module projected_point_bounds_unit_tb;
    import ppb_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = OUT_FRAC_BITS_DEF;
    localparam int EW = FB + 1;
    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

    typedef struct packed {
        logic [EW-1:0] u_min;
        logic [EW-1:0] v_min;
        logic [EW-1:0] u_max;
        logic [EW-1:0] v_max;
        logic          found;
    } t_box;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]                 i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]                 i_cfg_data = '0;
    logic                                  i_s_tvalid = 1'b0;
    logic                                  o_s_tready;
    logic [((3*CB+7)/8)*8-1:0]             i_s_tdata = '0;
    logic                                  i_s_tlast = 1'b0;
    logic                                  o_m_tvalid;
    logic                                  i_m_tready = 1'b0;
    logic [((4*EW+7)/8)*8-1:0]             o_m_tdata;
    logic                                  o_m_tuser;

    projected_point_bounds_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the block's registers and running box
    logic [63:0]        mat [7];
    logic               mat_valid;
    logic signed [31:0] acc_u_min, acc_v_min, acc_u_max, acc_v_max;
    logic               acc_any;

    t_box box_queue[$];
    int   mismatches = 0;
    int   points_sent = 0;
    int   boxes_seen = 0;
    int   boxes_found = 0;
    int   burst_left = 0;
    int   hold_req = 0;

    function automatic logic signed [63:0] sx32(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [63:0] clip_sum(logic [63:0] cxy, logic [63:0] czw,
                                                    logic signed [63:0] x,
                                                    logic signed [63:0] y,
                                                    logic signed [63:0] z);
        logic signed [63:0] px, py, pz, t;
        px = x * sx32(cxy[31:0]);
        py = y * sx32(cxy[63:32]);
        pz = z * sx32(czw[31:0]);
        t  = sx32(czw[63:32]);
        return (px >>> 3) + (py >>> 3) + (pz >>> 3) + (t <<< 21);
    endfunction

    // floor(num * 2^FB / den), saturated to 32 bits
    function automatic logic signed [31:0] ratio_q(logic signed [63:0] num, logic [63:0] den);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] wide, q, rem;
        neg = num[63];
        mag = neg ? -num : num;
        if (mag / den >= (64'd1 << (31 - FB)))
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        wide = {64'd0, mag} << FB;
        q    = wide / {64'd0, den};
        rem  = wide % {64'd0, den};
        if (neg) begin
            if (rem != 0) q = q + 1;
            return -q[31:0];
        end
        return q[31:0];
    endfunction

    function automatic logic [EW-1:0] clamp_edge(logic signed [31:0] v);
        if (v < 0) return '0;
        if (v > (32'sd1 << FB)) return EW'(1) << FB;
        return v[EW-1:0];
    endfunction

    function automatic void clear_box();
        acc_u_min = 32'sh7fff_ffff;
        acc_v_min = 32'sh7fff_ffff;
        acc_u_max = 32'sh8000_0000;
        acc_v_max = 32'sh8000_0000;
        acc_any   = 1'b0;
    endfunction

    // fold one accepted point into the running box, queue a box on the last one
    function automatic void project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic last);
        logic signed [63:0] cw, cx, cy;
        logic signed [31:0] u, v;
        t_box b;
        if (mat_valid) begin
            cw = clip_sum(mat[CFG_W_XY], mat[CFG_W_ZW], sx32(x), sx32(y), sx32(z));
            if (cw > 0) begin
                cx = clip_sum(mat[CFG_U_XY], mat[CFG_U_ZW], sx32(x), sx32(y), sx32(z));
                cy = clip_sum(mat[CFG_V_XY], mat[CFG_V_ZW], sx32(x), sx32(y), sx32(z));
                u = ratio_q(cx + cw, 2 * cw);
                v = ratio_q(cw - cy, 2 * cw);
                if (u < acc_u_min) acc_u_min = u;
                if (v < acc_v_min) acc_v_min = v;
                if (u > acc_u_max) acc_u_max = u;
                if (v > acc_v_max) acc_v_max = v;
                acc_any = 1'b1;
            end
        end
        if (!last) return;
        b = '0;
        if (mat_valid && acc_any) begin
            b.u_min = clamp_edge(acc_u_min);
            b.v_min = clamp_edge(acc_v_min);
            b.u_max = clamp_edge(acc_u_max);
            b.v_max = clamp_edge(acc_v_max);
            b.found = 1'b1;
        end
        box_queue = {box_queue, b};
        clear_box();
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = data;
        if (idx == CFG_MATRIX_VALID) mat_valid = data[0];
        else mat[idx] = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_matrix(logic [63:0] uxy, logic [63:0] uzw, logic [63:0] vxy,
                               logic [63:0] vzw, logic [63:0] wxy, logic [63:0] wzw,
                               logic mv);
        write_reg(CFG_U_XY, uxy);
        write_reg(CFG_U_ZW, uzw);
        write_reg(CFG_V_XY, vxy);
        write_reg(CFG_V_ZW, vzw);
        write_reg(CFG_W_XY, wxy);
        write_reg(CFG_W_ZW, wzw);
        write_reg(CFG_MATRIX_VALID, {63'd0, mv});
    endtask

    // one request on the input side; bursts of random length, sometimes with gaps between
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        if (burst_left == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid = 1'b1;
        i_s_tdata  = {z, y, x};
        i_s_tlast  = last;
        do @(posedge i_clk); while (!o_s_tready);
        project_point(x, y, z, last);
        points_sent++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (box_queue.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_box got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[EW-1:0], o_m_tdata[2*EW-1:EW], o_m_tdata[3*EW-1:2*EW],
                   o_m_tdata[4*EW-1:3*EW], o_m_tuser};
            boxes_seen++;
            if (got.found) boxes_found++;
            if (box_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected box %h", got);
            end else begin
                want = box_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("box mismatch: exp u %0d..%0d v %0d..%0d f %0b",
                                 want.u_min, want.u_max, want.v_min, want.v_max, want.found);
                        $display("              got u %0d..%0d v %0d..%0d f %0b",
                                 got.u_min, got.u_max, got.v_min, got.v_max, got.found);
                    end
                end
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off when asked
    initial begin
        int mode_left;
        int mode;
        int hold_left;
        mode_left = 0;
        mode = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else begin
                case (mode)
                    0: i_m_tready = 1'b1;
                    1: i_m_tready = ($urandom_range(0, 3) != 0);
                    default: i_m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_small(int range_q24);
        return $urandom_range(0, 2 * range_q24) - range_q24;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return rand_small(32'h0400_0000);
        endcase
    endfunction

    // mostly sane projections with positive w, the rest fully random
    task automatic random_matrix();
        logic [31:0] wt;
        if ($urandom_range(0, 4) == 0) begin
            load_matrix({$urandom(), $urandom()}, {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, {$urandom(), $urandom()},
                        $urandom_range(0, 7) != 0);
        end else begin
            wt = $urandom_range(ONE_Q24 / 4, 4 * ONE_Q24);
            load_matrix({rand_small(ONE_Q24 / 2), rand_small(2 * ONE_Q24)},
                        {rand_small(ONE_Q24), rand_small(2 * ONE_Q24)},
                        {rand_small(2 * ONE_Q24), rand_small(ONE_Q24 / 2)},
                        {rand_small(ONE_Q24), rand_small(2 * ONE_Q24)},
                        {rand_small(ONE_Q24 / 8), rand_small(ONE_Q24 / 8)},
                        {wt, rand_small(ONE_Q24 / 2)}, 1'b1);
        end
    endtask

    task automatic test_unloaded_matrix();
        send_point(32'h0100_0000, 32'h0, 32'h0, 1'b1);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
        wait_idle();
    endtask

    task automatic test_directed_edges();
        // matrix valid but all zero: w is zero, nothing projects
        load_matrix(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
        send_point(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 1'b1);
        wait_idle();
        // u = (x+1)/2, v = (1-y)/2 with w fixed at one
        load_matrix({32'd0, ONE_Q24}, 64'd0, {ONE_Q24, 32'd0}, 64'd0,
                    64'd0, {ONE_Q24, 32'd0}, 1'b1);
        send_point(32'hff00_0000, 32'h0100_0000, 32'h0, 1'b0);
        send_point(32'h0100_0000, 32'hff00_0000, 32'h0, 1'b1);
        send_point(32'h0300_0000, 32'hfd00_0000, 32'h0, 1'b1);
        send_point(32'hfd00_0000, 32'h0300_0000, 32'h0, 1'b1);
        send_point(32'h0080_0000, 32'h0040_0001, 32'hffff_ffff, 1'b1);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        wait_idle();
        // w of one raw step: ratio saturates
        load_matrix({32'd0, ONE_Q24}, 64'd0, {ONE_Q24, 32'd0}, 64'd0,
                    64'd0, {32'd1, 32'd0}, 1'b1);
        send_point(32'h0100_0000, 32'h0100_0000, 32'h0, 1'b1);
        send_point(32'hff00_0000, 32'hff00_0000, 32'h0, 1'b1);
        wait_idle();
        // w = z: negative z skipped, mixed set keeps only the positive one
        load_matrix({32'd0, ONE_Q24}, 64'd0, {ONE_Q24, 32'd0}, 64'd0,
                    64'd0, {32'd0, ONE_Q24}, 1'b1);
        send_point(32'h0, 32'h0, 32'hff00_0000, 1'b1);
        send_point(32'h0, 32'h0, 32'hff00_0000, 1'b0);
        send_point(32'h0080_0000, 32'h0, 32'h0200_0000, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b1);
        wait_idle();
        // extreme register contents
        load_matrix('1, '1, '1, '1, '1, '1, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'hffff_ffff, 32'h0, 32'h0, 1'b1);
        wait_idle();
        load_matrix({2{32'h7fff_ffff}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                    {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}}, 1'b1);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_sets(int n_points);
        int sent;
        int len;
        sent = 0;
        while (sent < n_points) begin
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
                random_matrix();
            end
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
                send_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
            sent += len;
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        random_matrix();
        write_reg(CFG_MATRIX_VALID, 64'd1);
        hold_req = 600;
        for (int k = 0; k < 20; k++)
            send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
        wait_idle();
    endtask

    initial begin
        for (int k = 0; k < 7; k++) mat[k] = '0;
        mat_valid = 1'b0;
        clear_box();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_unloaded_matrix();
        test_directed_edges();
        test_random_sets(1000);
        test_output_backpressure();
        test_random_sets(1000);
        load_matrix('0, '0, '0, '0, '0, '0, 1'b0);
        test_unloaded_matrix();
        $display("sent %0d points, checked %0d boxes (%0d found) over random matrices",
                 points_sent, boxes_seen, boxes_found);
        $display("mismatches: %0d", mismatches + box_queue.size());
        if (mismatches == 0 && box_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
